>>> hw/rtl/lccm_pkg.sv
// Light color command mixer: shared types, codes and constant-divide helpers.
// Used by lccm_ctrl, lccm_dp and light_color_command_mixer; depends on nothing.
package lccm_pkg;

    // Command codes on the action field
    localparam logic [2:0] ACT_HSV = 3'd0;
    localparam logic [2:0] ACT_HSL = 3'd1;
    localparam logic [2:0] ACT_CTB = 3'd2;
    localparam logic [2:0] ACT_OFF = 3'd3;
    localparam logic [2:0] ACT_ON  = 3'd4;

    // Stored light mode codes
    localparam logic [1:0] LIGHT_HSV = 2'd0;
    localparam logic [1:0] LIGHT_HSL = 2'd1;
    localparam logic [1:0] LIGHT_CTB = 2'd2;

    // Channel order and update masks
    localparam int NUM_CH  = 5;
    localparam int CH_RED  = 0;
    localparam int CH_GRN  = 1;
    localparam int CH_BLU  = 2;
    localparam int CH_WRM  = 3;
    localparam int CH_CLD  = 4;
    localparam logic [4:0] MASK_RGB = 5'b00111;
    localparam logic [4:0] MASK_WC  = 5'b11000;
    localparam logic [4:0] MASK_ALL = 5'b11111;

    // Arithmetic constants
    localparam int PCT_FULL    = 100;
    localparam int PCT_SQ      = 10000;
    localparam int HUE_MAX     = 360;
    localparam int HUE_SECTOR  = 60;
    localparam int HUE_WRAP    = 200;
    localparam int DUTY_FULL   = 255;
    localparam int WHITE_GAIN  = 86;
    localparam int WHITE_KNEE  = 15;
    localparam int WHITE_BASE  = 14;

    // Reciprocals: floor(x / d) = (x * R) >> n over the operand ranges used here
    localparam logic [12:0] RECIP_100   = 13'd5243;     // n = 19, x < 43690
    localparam logic [20:0] RECIP_10000 = 21'd1717987;  // n = 34, x <= 1e6
    localparam logic [9:0]  RECIP_3     = 10'd683;      // n = 11, x < 2048

    // Arithmetic steps after an item is taken
    localparam int NUM_STEPS = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CALC_NONE,
        CALC_HSV,
        CALC_HSL,
        CALC_CTB
    } t_calc;

    // Controller to datapath commands
    typedef struct packed {
        logic                 load;      // item taken this cycle
        logic [NUM_STEPS-1:0] step;      // one-hot arithmetic step enable
        logic                 out_load;  // result register written this cycle
    } t_cmd;

    // x / 100 for x up to 12799
    function automatic logic [6:0] div100(input logic [14:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'(RECIP_100);
        return prod[25:19];
    endfunction

    // x / 10000 for results up to 100
    function automatic logic [6:0] div10000(input logic [19:0] x);
        logic [40:0] prod;
        prod = 41'(x) * 41'(RECIP_10000);
        return prod[40:34];
    endfunction

    // x / 3 for x below 2048
    function automatic logic [9:0] div3(input logic [10:0] x);
        logic [20:0] prod;
        prod = 21'(x) * 21'(RECIP_3);
        return prod[20:11];
    endfunction

    // percent (0..100) to duty 0..255, truncated
    function automatic logic [7:0] duty(input logic [6:0] y);
        logic [14:0] scaled;
        logic [28:0] prod;
        scaled = 15'(y) * 15'(DUTY_FULL);
        prod   = 29'(scaled) * 29'(RECIP_100);
        return prod[26:19];
    endfunction

    // 60 degree sector of a hue below 360
    function automatic logic [2:0] hue_sector(input logic [8:0] h);
        logic [2:0] sec;
        sec = 3'd0;
        for (int i = 1; i < 6; i++) begin
            if (h >= 9'(i * HUE_SECTOR)) begin
                sec = 3'(i);
            end
        end
        return sec;
    endfunction

endpackage

>>> hw/rtl/lccm_ctrl.sv
// Light color command mixer: sequencing controller (take item, four steps, emit).
// Depends on lccm_pkg; drives the t_cmd bus into lccm_dp.
module lccm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lccm_pkg::t_cmd o_cmd
);
    import lccm_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    // State, step counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        cmd.load     = 1'b0;
        cmd.step     = '0;
        cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_CALC;
                    n_step   = '0;
                end
            end
            ST_CALC: begin
                cmd.step = NUM_STEPS'(1) << r_step;
                n_step   = r_step + 2'd1;
                if (r_step == 2'(NUM_STEPS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait until the result register is free or being drained
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load | (r_out_valid & i_out_stall);
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A taken item reaches the emit state after exactly four steps
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |-> ##5 (r_state == ST_EMIT))
        else $error("step sequence length wrong");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

>>> hw/rtl/lccm_dp.sv
// Light color command mixer: datapath with stored light state, operand decode,
// four arithmetic steps and the result register. Depends on lccm_pkg.
module lccm_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lccm_pkg::t_cmd i_cmd,
    input  logic [2:0]     i_action,
    input  logic [8:0]     i_hue,
    input  logic [7:0]     i_saturation,
    input  logic [7:0]     i_level,
    input  logic [7:0]     i_color_temp,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic [7:0]     o_warm,
    output logic [7:0]     o_cold,
    output logic [4:0]     o_update_mask,
    output logic [15:0]    o_fade_ms,
    output logic           o_light_on,
    output logic           o_status
);
    import lccm_pkg::*;

    // Stored light state
    logic [15:0] r_fade;
    logic [1:0]  r_mode, n_mode;
    logic        r_on, n_on;
    logic [8:0]  r_st_hue, n_st_hue;
    logic [6:0]  r_st_sat, n_st_sat;
    logic [6:0]  r_st_val, n_st_val;
    logic [6:0]  r_st_lgt, n_st_lgt;
    logic [6:0]  r_st_tmp, n_st_tmp;
    logic [6:0]  r_st_brt, n_st_brt;

    // Latched command
    t_calc       r_calc, n_calc;
    logic [4:0]  r_mask, n_mask;
    logic        r_bad, n_bad;
    logic [8:0]  r_op_h, n_op_h;
    logic [6:0]  r_op_s, n_op_s;
    logic [6:0]  r_op_l, n_op_l;   // value, lightness or brightness
    logic [6:0]  r_op_t, n_op_t;

    logic        hsv_ok, ctb_ok;
    logic [6:0]  val_on, lgt_on, brt_on;

    // Step 1
    logic [8:0]  hm;
    logic [2:0]  sec;
    logic [8:0]  hrem;
    logic [7:0]  l2, ldiff;
    logic [6:0]  cw;
    logic [2:0]  r_sec;
    logic [6:0]  r_f;
    logic [13:0] r_pnum, r_cnum, r_wnum, r_cwnum;
    logic [9:0]  r_xg;

    // Step 2
    logic [7:0]  xmod, xdist;
    logic [13:0] r_qnum, r_tnum;
    logic [6:0]  r_p, r_c, r_xf, r_w0, r_c0;

    // Step 3
    logic [19:0] r_qprod, r_tprod;
    logic [6:0]  r_m;
    logic [13:0] r_xprod, r_sw, r_sc;

    // Step 4
    logic [6:0]  q, t, x, cm, xm, wsh, csh;
    logic [6:0]  n_ch [NUM_CH];
    logic [6:0]  r_ch [NUM_CH];

    // Result register
    logic [7:0]  r_red, r_green, r_blue, r_warm, r_cold;
    logic [4:0]  r_upd;
    logic [15:0] r_fade_out;
    logic        r_light_on, r_status;

    // Decode the command, pick operands and the new stored state
    always_comb begin
        hsv_ok = (i_hue <= 9'(HUE_MAX)) && (i_saturation <= 8'(PCT_FULL))
                 && (i_level <= 8'(PCT_FULL));
        ctb_ok = (i_color_temp <= 8'(PCT_FULL)) && (i_level <= 8'(PCT_FULL));
        val_on = (r_st_val == '0) ? 7'(PCT_FULL) : r_st_val;
        lgt_on = (r_st_lgt == '0) ? 7'(PCT_FULL) : r_st_lgt;
        brt_on = (r_st_brt == '0) ? 7'(PCT_FULL) : r_st_brt;

        n_mode   = r_mode;
        n_on     = r_on;
        n_st_hue = r_st_hue;
        n_st_sat = r_st_sat;
        n_st_val = r_st_val;
        n_st_lgt = r_st_lgt;
        n_st_tmp = r_st_tmp;
        n_st_brt = r_st_brt;
        n_calc   = CALC_NONE;
        n_mask   = '0;
        n_bad    = 1'b0;
        n_op_h   = i_hue;
        n_op_s   = i_saturation[6:0];
        n_op_l   = i_level[6:0];
        n_op_t   = i_color_temp[6:0];

        case (i_action)
            ACT_HSV: begin
                if (!hsv_ok) begin
                    n_bad = 1'b1;
                end else begin
                    n_calc   = CALC_HSV;
                    n_mask   = MASK_RGB | ((r_mode != LIGHT_HSV) ? MASK_WC : 5'd0);
                    n_mode   = LIGHT_HSV;
                    n_on     = 1'b1;
                    n_st_hue = i_hue;
                    n_st_sat = i_saturation[6:0];
                    n_st_val = i_level[6:0];
                end
            end
            ACT_HSL: begin
                if (!hsv_ok) begin
                    n_bad = 1'b1;
                end else begin
                    n_calc   = CALC_HSL;
                    n_mask   = MASK_RGB | ((r_mode != LIGHT_HSL) ? MASK_WC : 5'd0);
                    n_mode   = LIGHT_HSL;
                    n_on     = 1'b1;
                    n_st_hue = i_hue;
                    n_st_sat = i_saturation[6:0];
                    n_st_lgt = i_level[6:0];
                end
            end
            ACT_CTB: begin
                if (!ctb_ok) begin
                    n_bad = 1'b1;
                end else begin
                    n_calc   = CALC_CTB;
                    n_mask   = MASK_WC | ((r_mode != LIGHT_CTB) ? MASK_RGB : 5'd0);
                    n_mode   = LIGHT_CTB;
                    n_on     = 1'b1;
                    n_st_tmp = i_color_temp[6:0];
                    n_st_brt = i_level[6:0];
                end
            end
            ACT_OFF: begin
                // all channels written with zero
                n_on   = 1'b0;
                n_mask = MASK_ALL;
            end
            ACT_ON: begin
                // replay the stored setting of the current mode
                n_on = 1'b1;
                case (r_mode)
                    LIGHT_HSV: begin
                        n_calc   = CALC_HSV;
                        n_mask   = MASK_RGB;
                        n_op_h   = r_st_hue;
                        n_op_s   = r_st_sat;
                        n_op_l   = val_on;
                        n_st_val = val_on;
                    end
                    LIGHT_HSL: begin
                        n_calc   = CALC_HSL;
                        n_mask   = MASK_RGB;
                        n_op_h   = r_st_hue;
                        n_op_s   = r_st_sat;
                        n_op_l   = lgt_on;
                        n_st_lgt = lgt_on;
                    end
                    LIGHT_CTB: begin
                        n_calc   = CALC_CTB;
                        n_mask   = MASK_WC;
                        n_op_t   = r_st_tmp;
                        n_op_l   = brt_on;
                        n_st_brt = brt_on;
                    end
                    default: begin
                        n_calc = CALC_NONE;
                    end
                endcase
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase
    end

    // Fade register and stored light state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade   <= '0;
            r_mode   <= LIGHT_HSV;
            r_on     <= 1'b1;
            r_st_hue <= 9'(HUE_MAX);
            r_st_sat <= '0;
            r_st_val <= 7'(PCT_FULL);
            r_st_lgt <= 7'(PCT_FULL);
            r_st_tmp <= '0;
            r_st_brt <= 7'd30;
        end else begin
            if (i_cfg_we) begin
                r_fade <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_mode   <= n_mode;
                r_on     <= n_on;
                r_st_hue <= n_st_hue;
                r_st_sat <= n_st_sat;
                r_st_val <= n_st_val;
                r_st_lgt <= n_st_lgt;
                r_st_tmp <= n_st_tmp;
                r_st_brt <= n_st_brt;
            end
        end
    end

    // Command and operand latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_calc <= n_calc;
            r_mask <= n_mask;
            r_bad  <= n_bad;
            r_op_h <= n_op_h;
            r_op_s <= n_op_s;
            r_op_l <= n_op_l;
            r_op_t <= n_op_t;
        end
    end

    // Step 1: sector, fraction, first products
    always_comb begin
        hm    = (r_op_h == 9'(HUE_MAX)) ? '0 : r_op_h;   // hue 360 acts as 0
        sec   = hue_sector(hm);
        hrem  = hm - 9'(9'(sec) * 9'(HUE_SECTOR));
        l2    = {r_op_l, 1'b0};
        ldiff = (l2 >= 8'(PCT_FULL)) ? (l2 - 8'(PCT_FULL)) : (8'(PCT_FULL) - l2);
        cw    = 7'(8'(PCT_FULL) - ldiff);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step[0]) begin
            r_sec   <= sec;
            r_f     <= 7'(div3(11'(hrem) * 11'd5));
            r_pnum  <= 14'(r_op_l) * 14'(7'(PCT_FULL) - r_op_s);
            r_cnum  <= 14'(cw) * 14'(r_op_s);
            r_xg    <= div3(11'(hm) * 11'd5);
            r_wnum  <= 14'(r_op_t) * 14'(r_op_l);
            r_cwnum <= 14'(7'(PCT_FULL) - r_op_t) * 14'(r_op_l);
        end
    end

    // Step 2: HSV numerators, percent quotients, HSL hue ramp
    always_comb begin
        if (r_xg >= 10'(2 * HUE_WRAP)) begin
            xmod = 8'(r_xg - 10'(2 * HUE_WRAP));
        end else if (r_xg >= 10'(HUE_WRAP)) begin
            xmod = 8'(r_xg - 10'(HUE_WRAP));
        end else begin
            xmod = 8'(r_xg);
        end
        xdist = (xmod >= 8'(PCT_FULL)) ? (xmod - 8'(PCT_FULL)) : (8'(PCT_FULL) - xmod);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step[1]) begin
            r_qnum <= 14'(PCT_SQ) - 14'(r_f) * 14'(r_op_s);
            r_tnum <= 14'(PCT_SQ) - 14'(r_op_s) * 14'(7'(PCT_FULL) - r_f);
            r_p    <= div100(15'(r_pnum));
            r_c    <= div100(15'(r_cnum));
            r_xf   <= 7'(8'(PCT_FULL) - xdist);
            r_w0   <= div100(15'(r_wnum));
            r_c0   <= div100(15'(r_cwnum));
        end
    end

    // Step 3: value products, HSL offset, white shaping products
    always_ff @(posedge i_clk) begin
        if (i_cmd.step[2]) begin
            r_qprod <= 20'(r_op_l) * 20'(r_qnum);
            r_tprod <= 20'(r_op_l) * 20'(r_tnum);
            r_m     <= r_op_l - 7'((8'(r_c) + 8'd1) >> 1);
            r_xprod <= 14'(r_c) * 14'(r_xf);
            r_sw    <= 14'(r_w0) * 14'(WHITE_GAIN);
            r_sc    <= 14'(r_c0) * 14'(WHITE_GAIN);
        end
    end

    // Step 4: final quotients and channel placement by sector
    always_comb begin
        q   = div10000(r_qprod);
        t   = div10000(r_tprod);
        x   = div100(15'(r_xprod));
        cm  = r_c + r_m;
        xm  = x + r_m;
        wsh = (r_w0 < 7'(WHITE_KNEE)) ? r_w0 : 7'(WHITE_BASE) + div100(15'(r_sw));
        csh = (r_c0 < 7'(WHITE_KNEE)) ? r_c0 : 7'(WHITE_BASE) + div100(15'(r_sc));
        for (int i = 0; i < NUM_CH; i++) begin
            n_ch[i] = '0;
        end
        case (r_calc)
            CALC_HSV: begin
                case (r_sec)
                    3'd0: begin n_ch[CH_RED] = r_op_l; n_ch[CH_GRN] = t; n_ch[CH_BLU] = r_p; end
                    3'd1: begin n_ch[CH_RED] = q; n_ch[CH_GRN] = r_op_l; n_ch[CH_BLU] = r_p; end
                    3'd2: begin n_ch[CH_RED] = r_p; n_ch[CH_GRN] = r_op_l; n_ch[CH_BLU] = t; end
                    3'd3: begin n_ch[CH_RED] = r_p; n_ch[CH_GRN] = q; n_ch[CH_BLU] = r_op_l; end
                    3'd4: begin n_ch[CH_RED] = t; n_ch[CH_GRN] = r_p; n_ch[CH_BLU] = r_op_l; end
                    default: begin
                        n_ch[CH_RED] = r_op_l; n_ch[CH_GRN] = r_p; n_ch[CH_BLU] = q;
                    end
                endcase
            end
            CALC_HSL: begin
                case (r_sec)
                    3'd0: begin n_ch[CH_RED] = cm; n_ch[CH_GRN] = xm; n_ch[CH_BLU] = r_m; end
                    3'd1: begin n_ch[CH_RED] = xm; n_ch[CH_GRN] = cm; n_ch[CH_BLU] = r_m; end
                    3'd2: begin n_ch[CH_RED] = r_m; n_ch[CH_GRN] = cm; n_ch[CH_BLU] = xm; end
                    3'd3: begin n_ch[CH_RED] = r_m; n_ch[CH_GRN] = xm; n_ch[CH_BLU] = cm; end
                    3'd4: begin n_ch[CH_RED] = xm; n_ch[CH_GRN] = r_m; n_ch[CH_BLU] = cm; end
                    default: begin
                        n_ch[CH_RED] = cm; n_ch[CH_GRN] = r_m; n_ch[CH_BLU] = xm;
                    end
                endcase
            end
            CALC_CTB: begin
                n_ch[CH_WRM] = wsh;
                n_ch[CH_CLD] = csh;
            end
            default: begin
                // off, bad argument or nothing to replay: all zero
                n_ch[CH_RED] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step[3]) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_ch[i] <= n_ch[i];
            end
        end
    end

    // Result register: percent to duty, unwritten channels read zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_red      <= r_mask[CH_RED] ? duty(r_ch[CH_RED]) : '0;
            r_green    <= r_mask[CH_GRN] ? duty(r_ch[CH_GRN]) : '0;
            r_blue     <= r_mask[CH_BLU] ? duty(r_ch[CH_BLU]) : '0;
            r_warm     <= r_mask[CH_WRM] ? duty(r_ch[CH_WRM]) : '0;
            r_cold     <= r_mask[CH_CLD] ? duty(r_ch[CH_CLD]) : '0;
            r_upd      <= r_mask;
            r_fade_out <= (r_mask != '0) ? r_fade : '0;
            r_light_on <= r_on;
            r_status   <= r_bad;
        end
    end

    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_warm        = r_warm;
    assign o_cold        = r_cold;
    assign o_update_mask = r_upd;
    assign o_fade_ms     = r_fade_out;
    assign o_light_on    = r_light_on;
    assign o_status      = r_status;

    // Channel levels never exceed full scale
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step[3] |=> (r_ch[CH_RED] <= 7'(PCT_FULL) && r_ch[CH_GRN] <= 7'(PCT_FULL)
                           && r_ch[CH_BLU] <= 7'(PCT_FULL) && r_ch[CH_WRM] <= 7'(PCT_FULL)
                           && r_ch[CH_CLD] <= 7'(PCT_FULL)))
        else $error("channel level out of range");

    // A rejected command writes nothing
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_bad) |=> (r_upd == '0 && r_fade_out == '0))
        else $error("rejected command produced an update");

    // Fade time only travels with an update
    a_fade_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_upd != '0 || r_fade_out == '0))
        else $error("fade time without update");

endmodule

>>> hw/rtl/light_color_command_mixer.sv
// Light color command mixer top level: controller plus datapath.
// Depends on lccm_pkg, lccm_ctrl and lccm_dp.

// Takes one light command (set HSV, set HSL, set warm share and brightness,
// switch off, switch on) and returns one result item with red, green, blue,
// warm and cold target duties, the update mask, the fade time, the on flag
// and a status bit. A command is taken while the input is not stalled; it then
// passes through four arithmetic steps in the multiply/constant-divide
// datapath and is loaded into the result register once that register is free.
// The input stays stalled from the taking of a command until its result is
// loaded, so the next command is taken only after that. A result that waits
// in the output register does not stop the next command from being taken and
// computed. The fade time register may be written whenever no command is in
// flight.
module light_color_command_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [8:0]  i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_level,
    input  logic [7:0]  i_color_temp,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_warm,
    output logic [7:0]  o_cold,
    output logic [4:0]  o_update_mask,
    output logic [15:0] o_fade_ms,
    output logic        o_light_on,
    output logic        o_status,
    // fade time register
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import lccm_pkg::*;

    t_cmd cmd;

    // Sequencer
    lccm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Arithmetic and light state
    lccm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_hue         (i_hue),
        .i_saturation  (i_saturation),
        .i_level       (i_level),
        .i_color_temp  (i_color_temp),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_warm        (o_warm),
        .o_cold        (o_cold),
        .o_update_mask (o_update_mask),
        .o_fade_ms     (o_fade_ms),
        .o_light_on    (o_light_on),
        .o_status      (o_status)
    );

endmodule

>>> bench/light_color_command_mixer_check.sv
`timescale 1ns / 1ps
// Result checker for the light color command mixer: predicts each result item from
// the accepted commands and compares it field by field. Depends on lccm_pkg.
module light_color_command_mixer_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_action,
    input  logic [8:0]  i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_level,
    input  logic [7:0]  i_color_temp,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_warm,
    input  logic [7:0]  i_cold,
    input  logic [4:0]  i_update_mask,
    input  logic [15:0] i_fade_ms,
    input  logic        i_light_on,
    input  logic        i_status,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_waiting
);
    import lccm_pkg::*;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_PARAM = 1'b1;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  warm;
        logic [7:0]  cold;
        logic [4:0]  update_mask;
        logic [15:0] fade_ms;
        logic        light_on;
        logic        status;
    } t_light_result;

    // Mirror of the mixer's stored setting
    logic [1:0]  mode;
    logic        on_flag;
    int          hue_s, sat_s, val_s, light_s, temp_s, bright_s;
    logic [15:0] fade_setting;

    t_light_result expected_q[$];
    t_light_result seen;
    int            results_seen    = 0;
    int            mismatch_count  = 0;
    int            waiting_count   = 0;

    assign o_mismatches = mismatch_count;
    assign o_waiting    = waiting_count;

    function automatic logic [7:0] pct_to_duty(input int x);
        return 8'(x * DUTY_FULL / PCT_FULL);
    endfunction

    // Knee on the white channels: small levels pass, larger ones are compressed
    function automatic int shape_white(input int x);
        return (x < WHITE_KNEE) ? x : WHITE_BASE + x * WHITE_GAIN / PCT_FULL;
    endfunction

    function automatic logic [23:0] hsv_rgb(input int h, input int s, input int v);
        int sec, f, p, q, t, a, b, c;
        sec = (h / HUE_SECTOR) % 6;
        f   = PCT_FULL * (h % HUE_SECTOR) / HUE_SECTOR;
        p   = v * (PCT_FULL - s) / PCT_FULL;
        q   = v * (PCT_SQ - f * s) / PCT_SQ;
        t   = v * (PCT_SQ - s * (PCT_FULL - f)) / PCT_SQ;
        case (sec)
            0: begin a = v; b = t; c = p; end
            1: begin a = q; b = v; c = p; end
            2: begin a = p; b = v; c = t; end
            3: begin a = p; b = q; c = v; end
            4: begin a = t; b = p; c = v; end
            default: begin a = v; b = p; c = q; end
        endcase
        return {pct_to_duty(a), pct_to_duty(b), pct_to_duty(c)};
    endfunction

    function automatic logic [23:0] hsl_rgb(input int h, input int s, input int l);
        int sec, c, m, x, ramp, a, b, d;
        sec  = (h / HUE_SECTOR) % 6;
        c    = (PCT_FULL - ((2 * l > PCT_FULL) ? 2 * l - PCT_FULL : PCT_FULL - 2 * l))
               * s / PCT_FULL;
        // midpoint rounds the half chroma up
        m    = l - (c + 1) / 2;
        ramp = (h * PCT_FULL / HUE_SECTOR) % HUE_WRAP;
        x    = c * (PCT_FULL - ((ramp > PCT_FULL) ? ramp - PCT_FULL : PCT_FULL - ramp))
               / PCT_FULL;
        case (sec)
            0: begin a = c + m; b = x + m; d = m;     end
            1: begin a = x + m; b = c + m; d = m;     end
            2: begin a = m;     b = c + m; d = x + m; end
            3: begin a = m;     b = x + m; d = c + m; end
            4: begin a = x + m; b = m;     d = c + m; end
            default: begin a = c + m; b = m; d = x + m; end
        endcase
        return {pct_to_duty(a), pct_to_duty(b), pct_to_duty(d)};
    endfunction

    // Sets a color in the given mode; a mode change also zeroes the other group
    function automatic t_light_result apply_color(input logic [1:0] new_mode, input int h,
                                                  input int s, input int lv, input int ct);
        t_light_result r;
        r = '0;
        case (new_mode)
            LIGHT_HSV: begin
                {r.red, r.green, r.blue} = hsv_rgb(h, s, lv);
                r.update_mask = MASK_RGB;
                hue_s = h;
                sat_s = s;
                val_s = lv;
            end
            LIGHT_HSL: begin
                {r.red, r.green, r.blue} = hsl_rgb(h, s, lv);
                r.update_mask = MASK_RGB;
                hue_s   = h;
                sat_s   = s;
                light_s = lv;
            end
            default: begin
                r.warm = pct_to_duty(shape_white(ct * lv / PCT_FULL));
                r.cold = pct_to_duty(shape_white((PCT_FULL - ct) * lv / PCT_FULL));
                r.update_mask = MASK_WC;
                temp_s   = ct;
                bright_s = lv;
            end
        endcase
        if (mode != new_mode) r.update_mask = MASK_ALL;
        mode    = new_mode;
        on_flag = 1'b1;
        return r;
    endfunction

    function automatic t_light_result predict_light(input logic [2:0] act, input int h,
                                                    input int s, input int lv, input int ct);
        t_light_result r;
        r = '0;
        r.status = STATUS_OK;
        case (act)
            ACT_HSV, ACT_HSL: begin
                if (h > HUE_MAX || s > PCT_FULL || lv > PCT_FULL)
                    r.status = STATUS_BAD_PARAM;
                else
                    r = apply_color((act == ACT_HSV) ? LIGHT_HSV : LIGHT_HSL, h, s, lv, 0);
            end
            ACT_CTB: begin
                if (ct > PCT_FULL || lv > PCT_FULL)
                    r.status = STATUS_BAD_PARAM;
                else
                    r = apply_color(LIGHT_CTB, 0, 0, lv, ct);
            end
            ACT_OFF: begin
                on_flag = 1'b0;
                r.update_mask = MASK_ALL;
            end
            ACT_ON: begin
                // replay stored setting, a zero level comes back at full
                on_flag = 1'b1;
                case (mode)
                    LIGHT_HSV: begin
                        if (val_s == 0) val_s = PCT_FULL;
                        r = apply_color(LIGHT_HSV, hue_s, sat_s, val_s, 0);
                    end
                    LIGHT_HSL: begin
                        if (light_s == 0) light_s = PCT_FULL;
                        r = apply_color(LIGHT_HSL, hue_s, sat_s, light_s, 0);
                    end
                    LIGHT_CTB: begin
                        if (bright_s == 0) bright_s = PCT_FULL;
                        r = apply_color(LIGHT_CTB, 0, 0, bright_s, temp_s);
                    end
                    default: ;
                endcase
            end
            default: r.status = STATUS_BAD_PARAM;
        endcase
        if (r.update_mask != '0) r.fade_ms = fade_setting;
        r.light_on = on_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch on result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Track config, score results, predict accepted commands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode         = LIGHT_HSV;
            on_flag      = 1'b1;
            hue_s        = HUE_MAX;
            sat_s        = 0;
            val_s        = PCT_FULL;
            light_s      = PCT_FULL;
            temp_s       = 0;
            bright_s     = 30;
            fade_setting = '0;
            expected_q.delete();
            waiting_count = 0;
        end else begin
            if (i_cfg_we) fade_setting = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                seen = {i_red, i_green, i_blue, i_warm, i_cold, i_update_mask, i_fade_ms,
                        i_light_on, i_status};
                if (expected_q.size() == 0) begin
                    report_mismatch("result item with no command waiting");
                end else begin
                    t_light_result want;
                    want = expected_q.pop_front();
                    check_field("red", seen.red, want.red);
                    check_field("green", seen.green, want.green);
                    check_field("blue", seen.blue, want.blue);
                    check_field("warm", seen.warm, want.warm);
                    check_field("cold", seen.cold, want.cold);
                    check_field("update_mask", seen.update_mask, want.update_mask);
                    check_field("fade_ms", seen.fade_ms, want.fade_ms);
                    check_field("light_on", seen.light_on, want.light_on);
                    check_field("status", seen.status, want.status);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(predict_light(i_action, int'(i_hue), int'(i_saturation),
                                                   int'(i_level), int'(i_color_temp)));
            waiting_count = expected_q.size();
        end
    end

endmodule

>>> bench/light_color_command_mixer_test.sv
`timescale 1ns / 1ps
// Testbench top for the light color command mixer: clock, reset, command and stall
// stimulus, fade time writes and the verdict. Depends on lccm_pkg, the block and the checker.
module light_color_command_mixer_test;
    import lccm_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASES       = 6;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cmd_valid   = 1'b0;
    logic        cmd_stall;
    logic [2:0]  action      = ACT_HSV;
    logic [8:0]  hue         = '0;
    logic [7:0]  saturation  = '0;
    logic [7:0]  level       = '0;
    logic [7:0]  color_temp  = '0;
    logic        res_valid;
    logic        res_stall   = 1'b0;
    logic [7:0]  red, green, blue, warm, cold;
    logic [4:0]  update_mask;
    logic [15:0] fade_ms;
    logic        light_on;
    logic        status;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_wdata   = '0;

    int mismatches;
    int pending;
    int cycles     = 0;
    bit quiet_run  = 1'b0;

    light_color_command_mixer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (cmd_valid),
        .o_in_stall    (cmd_stall),
        .i_action      (action),
        .i_hue         (hue),
        .i_saturation  (saturation),
        .i_level       (level),
        .i_color_temp  (color_temp),
        .o_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .o_red         (red),
        .o_green       (green),
        .o_blue        (blue),
        .o_warm        (warm),
        .o_cold        (cold),
        .o_update_mask (update_mask),
        .o_fade_ms     (fade_ms),
        .o_light_on    (light_on),
        .o_status      (status),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    light_color_command_mixer_check result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (cmd_valid),
        .i_in_stall    (cmd_stall),
        .i_action      (action),
        .i_hue         (hue),
        .i_saturation  (saturation),
        .i_level       (level),
        .i_color_temp  (color_temp),
        .i_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_warm        (warm),
        .i_cold        (cold),
        .i_update_mask (update_mask),
        .i_fade_ms     (fade_ms),
        .i_light_on    (light_on),
        .i_status      (status),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_waiting     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Called just after a rising edge; returns just after the edge that took the item
    task automatic send_command(input logic [2:0] act, input logic [8:0] h,
                                input logic [7:0] s, input logic [7:0] lv,
                                input logic [7:0] ct);
        int gap;
        bit took;
        gap = quiet_run ? 0 : $urandom_range(5, 0);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        action     <= act;
        hue        <= h;
        saturation <= s;
        level      <= lv;
        color_temp <= ct;
        do begin
            @(negedge clk);
            took = !cmd_stall;
            @(posedge clk);
        end while (!took);
    endtask

    // Hold off commands until every predicted result has been taken
    task automatic wait_until_idle();
        cmd_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_fade(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: hold the stall on each result for a random number of cycles, possibly none, once it shows up
    initial begin : result_side
        int hold;
        bit took;
        forever begin
            hold = quiet_run ? 0 : $urandom_range(5, 0);
            if (hold > 0) begin
                res_stall <= 1'b1;
                do @(negedge clk); while (res_valid !== 1'b1);
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do begin
                @(negedge clk);
                took = (res_valid === 1'b1);
                @(posedge clk);
            end while (!took);
        end
    end

    // Command side
    initial begin : command_side
        int h, s, lv, ct, pick;
        logic [2:0] act;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_fade(16'hFFFF);

        // Directed: replay of the reset setting, sector edges, mode changes,
        // zero levels raised by switch-on, the white knee, bad arguments
        send_command(ACT_ON, 9'd0, 8'd0, 8'd0, 8'd0);
        send_command(ACT_HSV, 9'd0, 8'd100, 8'd100, 8'd0);
        send_command(ACT_HSV, 9'd360, 8'd100, 8'd100, 8'd0);
        send_command(ACT_HSV, 9'd59, 8'd100, 8'd50, 8'd0);
        send_command(ACT_HSV, 9'd120, 8'd73, 8'd100, 8'd0);
        send_command(ACT_HSV, 9'd239, 8'd100, 8'd37, 8'd0);
        send_command(ACT_HSV, 9'd200, 8'd0, 8'd0, 8'd0);
        send_command(ACT_OFF, 9'd0, 8'd0, 8'd0, 8'd0);
        send_command(ACT_ON, 9'd0, 8'd0, 8'd0, 8'd0);
        send_command(ACT_HSL, 9'd60, 8'd100, 8'd50, 8'd0);
        send_command(ACT_HSL, 9'd300, 8'd77, 8'd25, 8'd0);
        send_command(ACT_HSL, 9'd180, 8'd100, 8'd0, 8'd0);
        send_command(ACT_ON, 9'd0, 8'd0, 8'd0, 8'd0);
        send_command(ACT_CTB, 9'd0, 8'd0, 8'd100, 8'd0);
        send_command(ACT_CTB, 9'd0, 8'd0, 8'd100, 8'd100);
        send_command(ACT_CTB, 9'd0, 8'd0, 8'd29, 8'd50);
        send_command(ACT_CTB, 9'd0, 8'd0, 8'd50, 8'd30);
        send_command(ACT_CTB, 9'd0, 8'd0, 8'd0, 8'd77);
        send_command(ACT_OFF, 9'd511, 8'd255, 8'd255, 8'd255);
        send_command(ACT_ON, 9'd0, 8'd0, 8'd0, 8'd0);
        send_command(ACT_HSV, 9'd361, 8'd50, 8'd50, 8'd0);
        send_command(ACT_HSL, 9'd0, 8'd101, 8'd50, 8'd0);
        send_command(ACT_HSV, 9'd0, 8'd0, 8'd101, 8'd0);
        send_command(ACT_CTB, 9'd0, 8'd0, 8'd50, 8'd101);
        send_command(ACT_CTB, 9'd511, 8'd255, 8'd50, 8'd50);
        for (int a = ACT_ON + 1; a < 8; a++)
            send_command(3'(a), 9'd511, 8'd255, 8'd255, 8'd255);

        // Random phases, each opened at idle with a new fade time
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_until_idle();
            case (phase)
                0: write_fade(16'h0000);
                1: write_fade(16'h0001);
                3: write_fade(16'h8000);
                5: write_fade(16'hFFFF);
                default: write_fade(16'($urandom));
            endcase
            quiet_run = (phase == 3);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                pick = $urandom_range(99, 0);
                h  = $urandom_range(HUE_MAX, 0);
                s  = $urandom_range(PCT_FULL, 0);
                lv = $urandom_range(PCT_FULL, 0);
                ct = $urandom_range(PCT_FULL, 0);
                if ($urandom_range(15, 0) == 0) h = HUE_MAX;
                if ($urandom_range(9, 0) == 0) lv = 0;
                if ($urandom_range(9, 0) == 0) s = PCT_FULL;
                if (pick < 10) begin
                    // noise: any action code with full-width fields
                    act = 3'($urandom_range(7, 0));
                    h   = $urandom_range(511, 0);
                    s   = $urandom_range(255, 0);
                    lv  = $urandom_range(255, 0);
                    ct  = $urandom_range(255, 0);
                end else if (pick < 35) begin
                    act = ACT_HSV;
                end else if (pick < 60) begin
                    act = ACT_HSL;
                end else if (pick < 80) begin
                    act = ACT_CTB;
                end else if (pick < 90) begin
                    act = ACT_OFF;
                end else begin
                    act = ACT_ON;
                end
                send_command(act, 9'(h), 8'(s), 8'(lv), 8'(ct));
            end
            quiet_run = 1'b0;
        end

        wait_until_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
